/* sv/rbps_pkg.sv */
// Shared constants and types for the rounded border pixel shader.
package rbps_pkg;

    // Default frame size limit, in pixels.
    localparam int MAX_DIM_DEF = 4096;

    // Field and register widths.
    localparam int COORD_W    = 12;
    localparam int REG13_W    = 13;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int EDGE_W     = 8;
    localparam int CHAN_W     = 8;
    localparam int PROD_W     = 2 * CHAN_W;

    // Geometry at doubled scale: signed working width, radius/offset width, square-sum width.
    localparam int GW   = 18;
    localparam int RW   = REG13_W + 1;
    localparam int SQ_W = 2 * RW + 1;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_WIDTHS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COLOR     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLOR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_COLOR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLOR    = 3'd7;

    // One axis of a rounded-rectangle test: inside the straight bounds, and
    // distance from the corner center along that axis (zero between corners).
    typedef struct packed {
        logic          inb;
        logic [RW-1:0] off;
    } t_axis;

endpackage

/* sv/rounded_border_pixel_shader.sv */
// Rounded-rectangle border shader: pixel coordinate in, premultiplied BGRA out.
// Three register stages: input beat, edge offsets and color products, result.
// One pixel per cycle sustained; a stall on the output backs up through all stages.
// Synchronous active-low reset clears stage valids and loads the register defaults:
// frame 1x1, radius 0, edge widths 0, all colors 0.
module rounded_border_pixel_shader #(
    parameter int MAX_DIM = rbps_pkg::MAX_DIM_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_we,
    input  logic [rbps_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rbps_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // pixel in
    input  logic                               i_pixel_valid,
    output logic                               o_pixel_ready,
    input  logic [rbps_pkg::COORD_W-1:0]       i_pixel_x,
    input  logic [rbps_pkg::COORD_W-1:0]       i_pixel_y,
    // color out
    output logic                               o_color_valid,
    input  logic                               i_color_ready,
    output logic [rbps_pkg::CHAN_W-1:0]        o_blue_out,
    output logic [rbps_pkg::CHAN_W-1:0]        o_green_out,
    output logic [rbps_pkg::CHAN_W-1:0]        o_red_out,
    output logic [rbps_pkg::CHAN_W-1:0]        o_alpha_out
);

    localparam int DIM_CLOG = $clog2(MAX_DIM + 1);
    localparam int DIM_W    = (DIM_CLOG < rbps_pkg::REG13_W) ? DIM_CLOG : rbps_pkg::REG13_W;
    localparam int GW       = rbps_pkg::GW;
    localparam int RW       = rbps_pkg::RW;
    localparam int SQ_W     = rbps_pkg::SQ_W;
    localparam int CW       = rbps_pkg::CHAN_W;
    localparam int PW       = rbps_pkg::PROD_W;
    localparam int EW       = rbps_pkg::EDGE_W;
    localparam int R13      = rbps_pkg::REG13_W;
    localparam int CRD      = rbps_pkg::COORD_W;

    // ---------------------------------------------------------------- config
    logic [R13-1:0]  r_frame_width;
    logic [R13-1:0]  r_frame_height;
    logic [R13-1:0]  r_corner_radius;
    logic [31:0]     r_edge_widths;
    logic [31:0]     r_top_color;
    logic [31:0]     r_right_color;
    logic [31:0]     r_bottom_color;
    logic [31:0]     r_left_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width   <= R13'(1);
            r_frame_height  <= R13'(1);
            r_corner_radius <= '0;
            r_edge_widths   <= '0;
            r_top_color     <= '0;
            r_right_color   <= '0;
            r_bottom_color  <= '0;
            r_left_color    <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbps_pkg::CFG_FRAME_WIDTH:   r_frame_width   <= i_cfg_data[R13-1:0];
                rbps_pkg::CFG_FRAME_HEIGHT:  r_frame_height  <= i_cfg_data[R13-1:0];
                rbps_pkg::CFG_CORNER_RADIUS: r_corner_radius <= i_cfg_data[R13-1:0];
                rbps_pkg::CFG_EDGE_WIDTHS:   r_edge_widths   <= i_cfg_data[31:0];
                rbps_pkg::CFG_TOP_COLOR:     r_top_color     <= i_cfg_data[31:0];
                rbps_pkg::CFG_RIGHT_COLOR:   r_right_color   <= i_cfg_data[31:0];
                rbps_pkg::CFG_BOTTOM_COLOR:  r_bottom_color  <= i_cfg_data[31:0];
                rbps_pkg::CFG_LEFT_COLOR:    r_left_color    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------- geometry from config
    logic [DIM_W-1:0] dim_w, dim_h;
    logic [EW-1:0]    tw, rw, bw, lw, widest;
    logic [R13-1:0]   inner_r;
    logic signed [GW-1:0] g_w2, g_h2, g_ro2, g_ri2;
    logic signed [GW-1:0] g_ix0, g_iy0, g_ix1, g_iy1;
    logic [2*RW-1:0]  ro_sq, ri_sq;
    logic [RW-1:0]    ro2_u, ri2_u;

    always_comb begin
        // zero size reads as one, oversize saturates
        if (r_frame_width == '0)
            dim_w = DIM_W'(1);
        else if (32'(r_frame_width) > 32'(MAX_DIM))
            dim_w = DIM_W'(MAX_DIM);
        else
            dim_w = r_frame_width[DIM_W-1:0];
        if (r_frame_height == '0)
            dim_h = DIM_W'(1);
        else if (32'(r_frame_height) > 32'(MAX_DIM))
            dim_h = DIM_W'(MAX_DIM);
        else
            dim_h = r_frame_height[DIM_W-1:0];

        tw = r_edge_widths[31:24];
        rw = r_edge_widths[23:16];
        bw = r_edge_widths[15:8];
        lw = r_edge_widths[7:0];
        widest = tw;
        if (bw > widest) widest = bw;
        if (lw > widest) widest = lw;
        if (rw > widest) widest = rw;
        inner_r = (r_corner_radius > R13'(widest)) ? r_corner_radius - R13'(widest) : '0;

        g_w2  = signed'({{(GW-DIM_W-1){1'b0}}, dim_w, 1'b0});
        g_h2  = signed'({{(GW-DIM_W-1){1'b0}}, dim_h, 1'b0});
        ro2_u = {r_corner_radius, 1'b0};
        ri2_u = {inner_r, 1'b0};
        g_ro2 = signed'({{(GW-RW){1'b0}}, ro2_u});
        g_ri2 = signed'({{(GW-RW){1'b0}}, ri2_u});
        g_ix0 = signed'({{(GW-EW-1){1'b0}}, lw, 1'b0});
        g_iy0 = signed'({{(GW-EW-1){1'b0}}, tw, 1'b0});
        g_ix1 = g_w2 - signed'({{(GW-EW-1){1'b0}}, rw, 1'b0});
        g_iy1 = g_h2 - signed'({{(GW-EW-1){1'b0}}, bw, 1'b0});
        ro_sq = ro2_u * ro2_u;
        ri_sq = ri2_u * ri2_u;
    end

    function automatic rbps_pkg::t_axis axis_off(input logic signed [GW-1:0] p,
                                                 input logic signed [GW-1:0] lo,
                                                 input logic signed [GW-1:0] hi,
                                                 input logic signed [GW-1:0] rad);
        logic signed [GW-1:0] lo_r, hi_r, d;
        rbps_pkg::t_axis res;
        lo_r = lo + rad;
        hi_r = hi - rad;
        res.inb = (p >= lo) && (p <= hi);
        if (p < lo_r)
            d = lo_r - p;
        else if (p > hi_r)
            d = p - hi_r;
        else
            d = '0;
        // within bounds the offset never exceeds the radius
        res.off = d[RW-1:0];
        return res;
    endfunction

    // floor(p/255) for any product of two 8-bit values (p up to 65025)
    function automatic logic [CW-1:0] div255(input logic [PW-1:0] p);
        logic [PW:0] t;
        t = (PW+1)'(p) + (PW+1)'(p[PW-1:CW]) + (PW+1)'(1);
        return t[PW-1:CW];
    endfunction

    // ------------------------------------------------------- pipeline flow
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;

    assign adv3          = !r_v3 || i_color_ready;
    assign adv2          = !r_v2 || adv3;
    assign adv1          = !r_v1 || adv2;
    assign o_pixel_ready = adv1;
    assign o_color_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_pixel_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // ---------------------------------------------------- stage 1: input beat
    logic [CRD-1:0] r_s1_px, r_s1_py;

    always_ff @(posedge i_clk) begin
        if (i_pixel_valid && adv1) begin
            r_s1_px <= i_pixel_x;
            r_s1_py <= i_pixel_y;
        end
    end

    // ---------------------------------- stage 2: offsets, edge pick, products
    logic signed [GW-1:0] px2, py2, d_bot, d_rgt;
    rbps_pkg::t_axis ox, oy, ix, iy;
    logic [31:0]   sel_color;
    logic [CW-1:0] n_s2_alpha;
    logic [PW-1:0] n_s2_pb, n_s2_pg, n_s2_pr;

    always_comb begin
        // pixel center at doubled scale
        px2 = signed'({{(GW-CRD-1){1'b0}}, r_s1_px, 1'b1});
        py2 = signed'({{(GW-CRD-1){1'b0}}, r_s1_py, 1'b1});
        ox  = axis_off(px2, '0, g_w2, g_ro2);
        oy  = axis_off(py2, '0, g_h2, g_ro2);
        ix  = axis_off(px2, g_ix0, g_ix1, g_ri2);
        iy  = axis_off(py2, g_iy0, g_iy1, g_ri2);

        // nearest edge, ties resolved top, bottom, left, right
        d_bot = g_h2 - py2;
        d_rgt = g_w2 - px2;
        if (py2 <= d_bot && py2 <= px2 && py2 <= d_rgt)
            sel_color = r_top_color;
        else if (d_bot <= px2 && d_bot <= d_rgt)
            sel_color = r_bottom_color;
        else if (px2 <= d_rgt)
            sel_color = r_left_color;
        else
            sel_color = r_right_color;

        n_s2_alpha = sel_color[31:24];
        n_s2_pb    = sel_color[7:0]   * n_s2_alpha;
        n_s2_pg    = sel_color[15:8]  * n_s2_alpha;
        n_s2_pr    = sel_color[23:16] * n_s2_alpha;
    end

    logic          r_s2_in_o, r_s2_in_i;
    logic [RW-1:0] r_s2_dxo, r_s2_dyo, r_s2_dxi, r_s2_dyi;
    logic [CW-1:0] r_s2_alpha;
    logic [PW-1:0] r_s2_pb, r_s2_pg, r_s2_pr;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r_s2_in_o  <= ox.inb && oy.inb;
            r_s2_in_i  <= ix.inb && iy.inb;
            r_s2_dxo   <= ox.off;
            r_s2_dyo   <= oy.off;
            r_s2_dxi   <= ix.off;
            r_s2_dyi   <= iy.off;
            r_s2_alpha <= n_s2_alpha;
            r_s2_pb    <= n_s2_pb;
            r_s2_pg    <= n_s2_pg;
            r_s2_pr    <= n_s2_pr;
        end
    end

    // ------------------------------------ stage 3: corner tests and result
    logic [SQ_W-1:0] sum_o, sum_i;
    logic            inside_o, inside_i, clear_px;

    always_comb begin
        sum_o    = SQ_W'(r_s2_dxo) * SQ_W'(r_s2_dxo) + SQ_W'(r_s2_dyo) * SQ_W'(r_s2_dyo);
        sum_i    = SQ_W'(r_s2_dxi) * SQ_W'(r_s2_dxi) + SQ_W'(r_s2_dyi) * SQ_W'(r_s2_dyi);
        inside_o = r_s2_in_o && (sum_o <= SQ_W'(ro_sq));
        inside_i = r_s2_in_i && (sum_i <= SQ_W'(ri_sq));
        clear_px = !inside_o || inside_i;
    end

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            o_blue_out  <= clear_px ? '0 : div255(r_s2_pb);
            o_green_out <= clear_px ? '0 : div255(r_s2_pg);
            o_red_out   <= clear_px ? '0 : div255(r_s2_pr);
            o_alpha_out <= clear_px ? '0 : r_s2_alpha;
        end
    end

    // ------------------------------------------------------------ checks
    a_zero_alpha_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_color_valid && o_alpha_out == '0 |->
            o_blue_out == '0 && o_green_out == '0 && o_red_out == '0)
        else $error("nonzero color with zero alpha");

    a_premul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_color_valid |->
            o_blue_out <= o_alpha_out && o_green_out <= o_alpha_out &&
            o_red_out <= o_alpha_out)
        else $error("premultiplied channel above alpha");

    a_backpressure_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_pixel_ready |-> r_v1 && r_v2 && r_v3 && !i_color_ready)
        else $error("input stalled with a free stage");

    a_stage2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && !adv2 |=> r_v2 && $stable(r_s2_alpha) && $stable(r_s2_in_o))
        else $error("stage 2 beat lost during stall");

endmodule
